[hw/rtl/pidl_pkg.sv]
// Shared types, sizes and codes for the positional insert/delete list.
`timescale 1ns / 1ps
`default_nettype none

package pidl_pkg;

  // List capacity and derived widths.
  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the stream beats.
  localparam int POS_W   = 8;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 6;
  localparam int STAT_W  = 2;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // One access request to the list memory.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  // One result beat handed to the output stage.
  typedef struct packed {
    logic [DATA_W-1:0]  element;
    logic               element_valid;
    logic [INDEX_W-1:0] index;
    logic [STAT_W-1:0]  status;
    logic               last;
  } out_beat_t;

endpackage

`default_nettype wire

[hw/rtl/pidl_ram.sv]
// List entry memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pidl_ram
  import pidl_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_req_t          req,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pidl_ctrl.sv]
// Sequencer: shifts list entries one step at a time and walks the readout.
`timescale 1ns / 1ps
`default_nettype none

module pidl_ctrl
  import pidl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  input  wire logic [POS_W-1:0]  in_pos,
  input  wire logic [DATA_W-1:0] in_val,
  output ram_req_t               ram_req,
  input  wire logic [DATA_W-1:0] ram_rd_data,
  input  wire logic              out_free,
  output logic                   beat_load,
  output out_beat_t              beat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SH_RD  = 3'd1;
  localparam logic [2:0] S_SH_WR  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_OUT_RD = 3'd4;
  localparam logic [2:0] S_OUT_LD = 3'd5;
  localparam logic [2:0] S_EMPTY  = 3'd6;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] cursor, cursor_next;
  logic [ADDR_W-1:0] slot, slot_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              op_r, op_r_next;
  logic [DATA_W-1:0] val_r, val_r_next;
  logic [STAT_W-1:0] status_r, status_r_next;

  // Position arithmetic on the incoming beat.
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    cnt_ext;
  logic [POS_W:0]    ins_slot;
  logic [ADDR_W-1:0] del_k;
  logic              full;
  logic              del_ok;

  // The shared cursor step and its compares.
  logic [ADDR_W-1:0] cursor_step;
  logic [CNT_W-1:0]  cursor_plus1;
  logic              is_last;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    pos_ext  = {1'b0, in_pos};
    cnt_ext  = (POS_W + 1)'(count);
    ins_slot = (in_pos == '0) ? '0 : pos_ext - (POS_W + 1)'(1);
    if (ins_slot > cnt_ext) begin
      ins_slot = cnt_ext;
    end
    del_k  = ADDR_W'(pos_ext - (POS_W + 1)'(1));
    full   = (count == CNT_W'(DEPTH));
    del_ok = (in_pos != '0) && (pos_ext <= cnt_ext);
  end

  // Insert walks the cursor down, delete and readout walk it up.
  assign cursor_step  = (op_r == OP_INSERT && state != S_OUT_LD) ?
                        cursor - ADDR_W'(1) : cursor + ADDR_W'(1);
  assign cursor_plus1 = CNT_W'(cursor) + CNT_W'(1);
  assign is_last      = (cursor_plus1 == count);

  // Next-state logic.
  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    slot_next     = slot;
    count_next    = count;
    op_r_next     = op_r;
    val_r_next    = val_r;
    status_r_next = status_r;
    ram_req       = '0;
    beat_load     = 1'b0;
    beat          = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next     = in_op;
          val_r_next    = in_val;
          status_r_next = ST_DONE;
          if (in_op == OP_INSERT) begin
            if (full) begin
              status_r_next = ST_FULL;
              cursor_next   = '0;
              state_next    = S_OUT_RD;
            end else begin
              slot_next   = ADDR_W'(ins_slot);
              cursor_next = ADDR_W'(count);
              state_next  = (cnt_ext > ins_slot) ? S_SH_RD : S_PUT;
            end
          end else begin
            if (!del_ok) begin
              status_r_next = ST_BAD_POS;
              cursor_next   = '0;
              state_next    = (count == '0) ? S_EMPTY : S_OUT_RD;
            end else if ((CNT_W'(del_k) + CNT_W'(1)) < count) begin
              cursor_next = del_k;
              state_next  = S_SH_RD;
            end else begin
              count_next  = count - CNT_W'(1);
              cursor_next = '0;
              state_next  = (count == CNT_W'(1)) ? S_EMPTY : S_OUT_RD;
            end
          end
        end
      end

      // Read the neighbor that moves into the cursor slot.
      S_SH_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = (op_r == OP_INSERT) ? cursor - ADDR_W'(1)
                                              : cursor + ADDR_W'(1);
        state_next      = S_SH_WR;
      end

      S_SH_WR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = cursor;
        ram_req.wr_data = ram_rd_data;
        cursor_next     = cursor_step;
        if (op_r == OP_INSERT) begin
          state_next = (cursor_step == slot) ? S_PUT : S_SH_RD;
        end else if ((CNT_W'(cursor_step) + CNT_W'(1)) < count) begin
          state_next = S_SH_RD;
        end else begin
          count_next  = count - CNT_W'(1);
          cursor_next = '0;
          state_next  = (count == CNT_W'(1)) ? S_EMPTY : S_OUT_RD;
        end
      end

      S_PUT: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = slot;
        ram_req.wr_data = val_r;
        count_next      = count + CNT_W'(1);
        cursor_next     = '0;
        state_next      = S_OUT_RD;
      end

      S_OUT_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = cursor;
        state_next      = S_OUT_LD;
      end

      // Hand one element to the output stage once it has room.
      S_OUT_LD: begin
        beat.element       = ram_rd_data;
        beat.element_valid = 1'b1;
        beat.index         = INDEX_W'(cursor);
        beat.status        = status_r;
        beat.last          = is_last;
        if (out_free) begin
          beat_load   = 1'b1;
          cursor_next = cursor_step;
          state_next  = is_last ? S_IDLE : S_OUT_RD;
        end
      end

      // An empty list gives one beat without an element.
      S_EMPTY: begin
        beat.status = status_r;
        beat.last   = 1'b1;
        if (out_free) begin
          beat_load  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers of the current operation.
  always_ff @(posedge clk) begin
    cursor   <= cursor_next;
    slot     <= slot_next;
    op_r     <= op_r_next;
    val_r    <= val_r_next;
    status_r <= status_r_next;
  end

endmodule

`default_nettype wire

[hw/rtl/positional_insert_delete_list_top.sv]
// Top level of the positional insert/delete list with its output stage.
// Operation: an insert at slot s shifts the entries from slot s upward, each shift
// step being one memory read and one write, then writes the value; a delete at slot
// s shifts the entries above s down the same way. The readout then reads each element
// from memory and loads it into the output register, waiting while the output stalls.
// A new request is accepted only once the readout of the last one has finished.
// Reset clears the count and the sequencer; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_list_top
  import pidl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // position [7:0], value [39:8]
  input  wire logic        s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // element [31:0], index [37:32], zero [39:38]
  output logic      [2:0]  m_tuser,   // element_valid [0], status [2:1]
  output logic             m_tlast
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rd_data;
  logic              out_free;
  logic              beat_load;
  out_beat_t         beat;

  pidl_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  pidl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_pos      (s_tdata[POS_W-1:0]),
    .in_val      (s_tdata[POS_W +: DATA_W]),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .out_free    (out_free),
    .beat_load   (beat_load),
    .beat        (beat)
  );

  // The output register may take a new beat when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (beat_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload of the output beat.
  always_ff @(posedge clk) begin
    if (beat_load) begin
      m_tdata <= {2'b00, beat.index, beat.element};
      m_tuser <= {beat.status, beat.element_valid};
      m_tlast <= beat.last;
    end
  end

endmodule

`default_nettype wire
